// ===== design/min_heap_priority_queue_top_assert.svh =====
// ----------------------------------------------------------------------------
// min_heap_priority_queue_top_assert.svh
// assertion macros used by the heap queue datapath
// ----------------------------------------------------------------------------
`ifndef MIN_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define MIN_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define MHPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap queue check failed");

// next-cycle implication, disabled while reset is held
`define MHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap queue check failed");

`endif

// ===== design/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mhpq_pkg
// shared sizes, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package mhpq_pkg;

    // heap sizing
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int POS_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 7;

    // item modes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        RES_OK    = 2'd0,
        RES_FULL  = 2'd1,
        RES_EMPTY = 2'd2
    } t_res_status;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_LOAD      = 4'd1,
        OP_INS_READ  = 4'd2,
        OP_INS_MOVE  = 4'd3,
        OP_INS_PLACE = 4'd4,
        OP_DEL_TOP   = 4'd5,
        OP_DEL_LAST  = 4'd6,
        OP_DEL_READ  = 4'd7,
        OP_DEL_LEFT  = 4'd8,
        OP_DEL_PICK  = 4'd9,
        OP_DEL_MOVE  = 4'd10,
        OP_DEL_PLACE = 4'd11,
        OP_OUT       = 4'd12
    } t_op;

    // datapath flags seen by the controller
    typedef struct packed {
        logic fail;
        logic at_root;
        logic parent_gt;
        logic has_child;
        logic has_right;
        logic moving_le;
        logic out_free;
    } t_dp_status;

endpackage

// ===== design/mhpq_dp.sv =====
// ----------------------------------------------------------------------------
// mhpq_dp
// heap store, sift registers, compares and the result register
// ----------------------------------------------------------------------------
`include "min_heap_priority_queue_top_assert.svh"

module mhpq_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mhpq_pkg::t_op                    i_op,
    input  logic                             i_mode,
    input  logic signed [mhpq_pkg::DATA_W-1:0] i_value,
    input  logic                             i_stall,
    output mhpq_pkg::t_dp_status             o_st,
    output logic                             o_valid,
    output logic signed [mhpq_pkg::DATA_W-1:0] o_popped,
    output logic [mhpq_pkg::COUNT_W-1:0]     o_count,
    output logic                             o_empty_res,
    output logic [1:0]                       o_res_status
);

    localparam int PW = mhpq_pkg::POS_W;

    // heap store, position p lives at address p-1
    logic signed [mhpq_pkg::DATA_W-1:0] r_mem [mhpq_pkg::CAPACITY];
    logic signed [mhpq_pkg::DATA_W-1:0] r_rdata;

    logic [PW-1:0]                      r_count;
    logic [PW-1:0]                      r_pos;
    logic [PW-1:0]                      r_child;
    logic signed [mhpq_pkg::DATA_W-1:0] r_val;
    logic signed [mhpq_pkg::DATA_W-1:0] r_cval;
    logic signed [mhpq_pkg::DATA_W-1:0] r_top;
    mhpq_pkg::t_res_status              r_status;

    logic                               r_ovalid;
    logic signed [mhpq_pkg::DATA_W-1:0] r_opopped;
    logic [mhpq_pkg::COUNT_W-1:0]       r_ocount;
    logic                               r_oempty;
    mhpq_pkg::t_res_status              r_ostatus;

    logic                               rd_en;
    logic [mhpq_pkg::ADDR_W-1:0]        rd_addr;
    logic                               wr_en;
    logic [mhpq_pkg::ADDR_W-1:0]        wr_addr;
    logic signed [mhpq_pkg::DATA_W-1:0] wr_data;
    logic [PW:0]                        left_pos;
    logic [PW:0]                        right_pos;
    logic                               full;
    logic                               empty;

    // tree arithmetic
    assign left_pos  = {r_pos, 1'b0};
    assign right_pos = {1'b0, r_child} + (PW+1)'(1);
    assign full      = (r_count == PW'(mhpq_pkg::CAPACITY));
    assign empty     = (r_count == '0);

    // status flags to the controller
    always_comb begin
        o_st.fail      = ((i_mode == mhpq_pkg::MODE_INSERT) && full) ||
                         ((i_mode == mhpq_pkg::MODE_DELETE) && empty);
        o_st.at_root   = (r_pos == PW'(1));
        o_st.parent_gt = (r_rdata > r_val);
        o_st.has_child = (left_pos <= {1'b0, r_count});
        o_st.has_right = (right_pos <= {1'b0, r_count});
        o_st.moving_le = (r_val <= r_cval);
        o_st.out_free  = !r_ovalid || !i_stall;
    end

    // memory address and write selection
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = mhpq_pkg::ADDR_W'(r_pos - PW'(1));
        wr_data = r_val;
        case (i_op)
            mhpq_pkg::OP_LOAD: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            mhpq_pkg::OP_INS_READ: begin
                rd_en   = 1'b1;
                rd_addr = mhpq_pkg::ADDR_W'((r_pos >> 1) - PW'(1));
            end
            mhpq_pkg::OP_INS_MOVE: begin
                wr_en   = 1'b1;
                wr_data = r_rdata;
            end
            mhpq_pkg::OP_INS_PLACE: begin
                wr_en = 1'b1;
            end
            mhpq_pkg::OP_DEL_TOP: begin
                rd_en   = 1'b1;
                rd_addr = mhpq_pkg::ADDR_W'(r_count - PW'(1));
            end
            mhpq_pkg::OP_DEL_READ: begin
                rd_en   = 1'b1;
                rd_addr = mhpq_pkg::ADDR_W'(left_pos - (PW+1)'(1));
            end
            mhpq_pkg::OP_DEL_LEFT: begin
                // right child sits at address r_child
                rd_en   = 1'b1;
                rd_addr = mhpq_pkg::ADDR_W'(r_child);
            end
            mhpq_pkg::OP_DEL_MOVE: begin
                wr_en   = 1'b1;
                wr_data = r_cval;
            end
            mhpq_pkg::OP_DEL_PLACE: begin
                wr_en = 1'b1;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // heap store with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_op == mhpq_pkg::OP_INS_PLACE) begin
            r_count <= r_count + PW'(1);
        end else if (i_op == mhpq_pkg::OP_DEL_LAST) begin
            r_count <= r_count - PW'(1);
        end
    end

    // sift registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            mhpq_pkg::OP_LOAD: begin
                r_val <= i_value;
                r_pos <= r_count + PW'(1);
                r_top <= '0;
                if ((i_mode == mhpq_pkg::MODE_INSERT) && full) begin
                    r_status <= mhpq_pkg::RES_FULL;
                end else if ((i_mode == mhpq_pkg::MODE_DELETE) && empty) begin
                    r_status <= mhpq_pkg::RES_EMPTY;
                end else begin
                    r_status <= mhpq_pkg::RES_OK;
                end
            end
            mhpq_pkg::OP_INS_MOVE: begin
                r_pos <= r_pos >> 1;
            end
            mhpq_pkg::OP_DEL_TOP: begin
                r_top <= r_rdata;
            end
            mhpq_pkg::OP_DEL_LAST: begin
                r_val <= r_rdata;
                r_pos <= PW'(1);
            end
            mhpq_pkg::OP_DEL_READ: begin
                r_child <= PW'(left_pos);
            end
            mhpq_pkg::OP_DEL_LEFT: begin
                r_cval <= r_rdata;
            end
            mhpq_pkg::OP_DEL_PICK: begin
                // right child wins only when strictly smaller
                if (r_rdata < r_cval) begin
                    r_cval  <= r_rdata;
                    r_child <= PW'(right_pos);
                end
            end
            mhpq_pkg::OP_DEL_MOVE: begin
                r_pos <= r_child;
            end
            default: begin
                r_pos <= r_pos;
            end
        endcase
    end

    // result register, one beat per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_op == mhpq_pkg::OP_OUT) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == mhpq_pkg::OP_OUT) begin
            r_opopped <= r_top;
            r_ocount  <= mhpq_pkg::COUNT_W'(r_count);
            r_oempty  <= empty;
            r_ostatus <= r_status;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_popped     = r_opopped;
    assign o_count      = r_ocount;
    assign o_empty_res  = r_oempty;
    assign o_res_status = r_ostatus;

    // checks
    `MHPQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= PW'(mhpq_pkg::CAPACITY))
    `MHPQ_ASSERT_NEXT(a_ins_count, i_clk, i_rst_n, i_op == mhpq_pkg::OP_INS_PLACE, r_count == $past(r_count) + PW'(1))
    `MHPQ_ASSERT_NEXT(a_sift_up, i_clk, i_rst_n, i_op == mhpq_pkg::OP_INS_MOVE, r_pos == ($past(r_pos) >> 1))
    `MHPQ_ASSERT_NOW(a_empty_flag, i_clk, i_rst_n, r_ovalid, r_oempty == (r_ostatus == mhpq_pkg::RES_EMPTY || r_ocount == '0))

endmodule

// ===== design/mhpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mhpq_ctrl
// sequencer for insert sift-up, delete sift-down and result handoff
// ----------------------------------------------------------------------------
module mhpq_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_mode,
    input  mhpq_pkg::t_dp_status i_st,
    output mhpq_pkg::t_op        o_op,
    output logic                 o_stall
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_INS_CHK  = 10'b00_0000_0010,
        S_INS_WAIT = 10'b00_0000_0100,
        S_DEL_TOP  = 10'b00_0000_1000,
        S_DEL_LAST = 10'b00_0001_0000,
        S_DEL_CHK  = 10'b00_0010_0000,
        S_DEL_L    = 10'b00_0100_0000,
        S_DEL_R    = 10'b00_1000_0000,
        S_DEL_CMP  = 10'b01_0000_0000,
        S_RESULT   = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // input side is open only between items
    assign o_stall = (r_state != S_IDLE);

    // next state and datapath operation
    always_comb begin
        n_state = r_state;
        o_op    = mhpq_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_op = mhpq_pkg::OP_LOAD;
                    if (i_st.fail) begin
                        n_state = S_RESULT;
                    end else if (i_mode == mhpq_pkg::MODE_INSERT) begin
                        n_state = S_INS_CHK;
                    end else begin
                        n_state = S_DEL_TOP;
                    end
                end
            end
            S_INS_CHK: begin
                if (i_st.at_root) begin
                    o_op    = mhpq_pkg::OP_INS_PLACE;
                    n_state = S_RESULT;
                end else begin
                    o_op    = mhpq_pkg::OP_INS_READ;
                    n_state = S_INS_WAIT;
                end
            end
            S_INS_WAIT: begin
                if (i_st.parent_gt) begin
                    o_op    = mhpq_pkg::OP_INS_MOVE;
                    n_state = S_INS_CHK;
                end else begin
                    o_op    = mhpq_pkg::OP_INS_PLACE;
                    n_state = S_RESULT;
                end
            end
            S_DEL_TOP: begin
                o_op    = mhpq_pkg::OP_DEL_TOP;
                n_state = S_DEL_LAST;
            end
            S_DEL_LAST: begin
                o_op    = mhpq_pkg::OP_DEL_LAST;
                n_state = S_DEL_CHK;
            end
            S_DEL_CHK: begin
                if (i_st.has_child) begin
                    o_op    = mhpq_pkg::OP_DEL_READ;
                    n_state = S_DEL_L;
                end else begin
                    o_op    = mhpq_pkg::OP_DEL_PLACE;
                    n_state = S_RESULT;
                end
            end
            S_DEL_L: begin
                o_op    = mhpq_pkg::OP_DEL_LEFT;
                n_state = i_st.has_right ? S_DEL_R : S_DEL_CMP;
            end
            S_DEL_R: begin
                o_op    = mhpq_pkg::OP_DEL_PICK;
                n_state = S_DEL_CMP;
            end
            S_DEL_CMP: begin
                if (i_st.moving_le) begin
                    o_op    = mhpq_pkg::OP_DEL_PLACE;
                    n_state = S_RESULT;
                end else begin
                    o_op    = mhpq_pkg::OP_DEL_MOVE;
                    n_state = S_DEL_CHK;
                end
            end
            S_RESULT: begin
                if (i_st.out_free) begin
                    o_op    = mhpq_pkg::OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/min_heap_priority_queue_top.sv =====
// result valid follows the sift: an insert ends when it rises to the root or meets a parent that is
// not greater, a delete when the moving entry has no child or is not greater than the smaller child
// a full-heap insert or empty-heap delete skips the sift and goes from the load to the result state
// throughput: one item at a time, the next beat is taken the cycle after the result loads;
// a finished result waits in the result state while the previous one is still valid and stalled
// reset: synchronous active low, empties the heap and drops any pending result
// ----------------------------------------------------------------------------
// min_heap_priority_queue_top
// binary min-heap priority queue with insert and delete-minimum items
// ----------------------------------------------------------------------------
module min_heap_priority_queue_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_mode,
    input  logic signed [mhpq_pkg::DATA_W-1:0] i_value,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [mhpq_pkg::DATA_W-1:0] o_popped,
    output logic [mhpq_pkg::COUNT_W-1:0]       o_count,
    output logic                               o_empty_res,
    output logic [1:0]                         o_status
);

    mhpq_pkg::t_op        op;
    mhpq_pkg::t_dp_status st;

    // sequencer
    mhpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .i_st    (st),
        .o_op    (op),
        .o_stall (o_stall)
    );

    // heap store and result register
    mhpq_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (op),
        .i_mode       (i_mode),
        .i_value      (i_value),
        .i_stall      (i_stall),
        .o_st         (st),
        .o_valid      (o_valid),
        .o_popped     (o_popped),
        .o_count      (o_count),
        .o_empty_res  (o_empty_res),
        .o_res_status (o_status)
    );

endmodule
